### rtl/b64d_pkg.sv
// Package for the streaming base64 decoder.
// Holds the symbol decode function, the job record passed from front to back, and defaults.
// No dependencies.
package b64d_pkg;

   // Pad character that stops decoding until the end of the source
   localparam logic [7:0] PadChar = 8'h3D;

   // Default depth of the job queue between front and back
   localparam int DefaultQueueDepth = 4;

   // Decoded symbol: ok is clear for characters outside the alphabet
   typedef struct packed {
      logic       ok;
      logic [5:0] val;
   } sym_type;

   // One job: up to three results produced by a single request
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] count;     // number of results, 1..3
      logic       data_ok;   // results carry decoded bytes
      logic       fin;       // last result of the job closes the stream
      logic       bad;       // one dangling symbol at the end
   } job_type;

   // Map a character onto its 6-bit alphabet value
   function automatic sym_type sym_decode(input logic [7:0] c);
      sym_type s;
      logic [7:0] d;
      s = '{ok: 1'b0, val: 6'd0};
      d = 8'd0;
      if (c >= 8'h41 && c <= 8'h5A) begin
         d = c - 8'h41;
         s = '{ok: 1'b1, val: d[5:0]};
      end else if (c >= 8'h61 && c <= 8'h7A) begin
         d = c - 8'h61 + 8'd26;
         s = '{ok: 1'b1, val: d[5:0]};
      end else if (c >= 8'h30 && c <= 8'h39) begin
         d = c - 8'h30 + 8'd52;
         s = '{ok: 1'b1, val: d[5:0]};
      end else if (c == 8'h2B) begin
         s = '{ok: 1'b1, val: 6'd62};
      end else if (c == 8'h2F) begin
         s = '{ok: 1'b1, val: 6'd63};
      end
      return s;
   endfunction

endpackage

### rtl/b64d_if.sv
// Handshake interfaces for the base64 decoder request and response channels.
// Depends on nothing; used by the decoder modules.
interface b64d_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_char;
   logic       end_of_source;

   modport source (output valid, output in_char, output end_of_source, input ready);
   modport sink (input valid, input in_char, input end_of_source, output ready);
endinterface

interface b64d_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       byte_valid;
   logic       final_result;
   logic       bad_length;

   modport source (output valid, output out_byte, output byte_valid,
                   output final_result, output bad_length, input ready);
   modport sink (input valid, input out_byte, input byte_valid,
                 input final_result, input bad_length, output ready);
endinterface

### rtl/base64_stream_decoder.sv
// Streaming base64 decoder, one character per request.
// Throughput: one request per cycle while the job queue has room; one response per cycle
// while the receiver is ready. A request that produces output passes through the job
// queue into the back-end output register; a four-symbol group drains as three responses.
// Reset: synchronous; clears accumulator, symbol count, pad flag, queue state, output valid.
// Depends on b64d_pkg, b64d_if, b64d_front, b64d_queue and b64d_back.
module base64_stream_decoder
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
   input  logic        clock,
   input  logic        reset,
   b64d_req_if.sink    req_chan,
   b64d_rsp_if.source  rsp_chan
);

   logic    q_ready;
   logic    q_push;
   job_type q_push_job;
   logic    q_pop;
   logic    q_valid;
   job_type q_head_job;

   // classify characters and build jobs
   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req         (req_chan),
      .queue_ready (q_ready),
      .push        (q_push),
      .job         (q_push_job)
   );

   // decouple front from back
   b64d_queue #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_job  (q_push_job),
      .not_full  (q_ready),
      .pop       (q_pop),
      .not_empty (q_valid),
      .head_job  (q_head_job)
   );

   // serialize jobs into responses
   b64d_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (q_valid),
      .head_job   (q_head_job),
      .pop        (q_pop),
      .rsp        (rsp_chan)
   );

endmodule

### rtl/b64d_front.sv
// Front end: accepts characters, tracks the symbol accumulator and builds output jobs.
// Depends on b64d_pkg and b64d_req_if.
module b64d_front
   import b64d_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   b64d_req_if.sink       req,
   input  logic           queue_ready,
   output logic           push,
   output job_type        job
);

   logic [17:0] acc_ff, acc_in;
   logic [1:0]  cnt_ff, cnt_in;
   logic        pad_ff, pad_in;

   sym_type     sym;
   logic        accept;
   logic        is_pad;
   logic        take_sym;
   logic        group_done;
   logic [17:0] acc_shift;
   logic [17:0] acc_eff;
   logic [1:0]  cnt_eff;

   assign req.ready = queue_ready;
   assign accept    = req.valid && queue_ready;

   // classify the character
   always_comb begin
      sym        = sym_decode(req.in_char);
      is_pad     = (req.in_char == PadChar);
      take_sym   = !pad_ff && !is_pad && sym.ok;
      group_done = take_sym && (cnt_ff == 2'd3);
      acc_shift  = {acc_ff[11:0], sym.val};
      acc_eff    = take_sym ? acc_shift : acc_ff;
      cnt_eff    = take_sym ? cnt_ff + 2'd1 : cnt_ff;
   end

   // build the job for this request
   always_comb begin
      job = '{byte0: 8'd0, byte1: 8'd0, byte2: 8'd0, count: 2'd1,
              data_ok: 1'b0, fin: 1'b1, bad: 1'b0};
      if (group_done) begin
         job = '{byte0: acc_shift[17:10], byte1: {acc_shift[9:2]},
                 byte2: {acc_shift[1:0], 6'd0}, count: 2'd3, data_ok: 1'b1,
                 fin: req.end_of_source, bad: 1'b0};
         // three full bytes: the 18 held accumulator bits plus the fourth symbol make 24 bits
         job.byte0 = {acc_ff[17:12], acc_ff[11:10]};
         job.byte1 = {acc_ff[9:6], acc_ff[5:2]};
         job.byte2 = {acc_ff[1:0], sym.val};
      end else begin
         case (cnt_eff)
            2'd1: begin
               job.bad = 1'b1;
            end
            2'd2: begin
               job.byte0   = acc_eff[11:4];
               job.data_ok = 1'b1;
            end
            2'd3: begin
               job.byte0   = acc_eff[17:10];
               job.byte1   = acc_eff[9:2];
               job.count   = 2'd2;
               job.data_ok = 1'b1;
            end
            default: begin
               job.data_ok = 1'b0;
            end
         endcase
      end
   end

   assign push = accept && (group_done || req.end_of_source);

   // next state
   always_comb begin
      acc_in = acc_ff;
      cnt_in = cnt_ff;
      pad_in = pad_ff;
      if (accept) begin
         if (req.end_of_source || group_done) begin
            acc_in = 18'd0;
            cnt_in = 2'd0;
         end else if (take_sym) begin
            acc_in = acc_shift;
            cnt_in = cnt_eff;
         end
         if (req.end_of_source) begin
            pad_in = 1'b0;
         end else if (!pad_ff && is_pad) begin
            pad_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= 18'd0;
         cnt_ff <= 2'd0;
         pad_ff <= 1'b0;
      end else begin
         acc_ff <= acc_in;
         cnt_ff <= cnt_in;
         pad_ff <= pad_in;
      end
   end

endmodule

### rtl/b64d_queue.sv
// Job queue between the decoder front and back ends.
// Depends on b64d_pkg.
module b64d_queue
   import b64d_pkg::*;
#(
   parameter int QUEUE_DEPTH = DefaultQueueDepth
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    not_full,
   input  logic    pop,
   output logic    not_empty,
   output job_type head_job
);

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PtrW-1:0] LastPtr = PtrW'(QUEUE_DEPTH - 1);
   localparam logic [CntW-1:0] FullCnt = CntW'(QUEUE_DEPTH);

   job_type         mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0] wr_ff, wr_in;
   logic [PtrW-1:0] rd_ff, rd_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   logic            do_push;
   logic            do_pop;

   assign not_full  = (cnt_ff != FullCnt);
   assign not_empty = (cnt_ff != '0);
   assign head_job  = mem_ff[rd_ff];
   assign do_push   = push && not_full;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == LastPtr) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == LastPtr) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_job;
      end
   end

endmodule

### rtl/b64d_back.sv
// Back end: walks queued jobs; output register gives one response per cycle unless stalled.
// Depends on b64d_pkg and b64d_rsp_if.
module b64d_back
   import b64d_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        head_valid,
   input  job_type     head_job,
   output logic        pop,
   b64d_rsp_if.source  rsp
);

   logic [1:0] idx_ff, idx_in;
   logic       vld_ff, vld_in;
   logic [7:0] byte_ff, byte_in;
   logic       bv_ff, bv_in;
   logic       fin_ff, fin_in;
   logic       bad_ff, bad_in;

   logic       load;
   logic       last;
   logic [7:0] sel_byte;

   assign load = head_valid && (!vld_ff || rsp.ready);
   assign last = ((idx_ff + 2'd1) == head_job.count);
   assign pop  = load && last;

   // pick the byte for the current position in the job
   always_comb begin
      case (idx_ff)
         2'd0:    sel_byte = head_job.byte0;
         2'd1:    sel_byte = head_job.byte1;
         2'd2:    sel_byte = head_job.byte2;
         default: sel_byte = 8'd0;
      endcase
   end

   // output register and job position
   always_comb begin
      idx_in  = idx_ff;
      vld_in  = vld_ff;
      byte_in = byte_ff;
      bv_in   = bv_ff;
      fin_in  = fin_ff;
      bad_in  = bad_ff;
      if (load) begin
         vld_in  = 1'b1;
         byte_in = head_job.data_ok ? sel_byte : 8'd0;
         bv_in   = head_job.data_ok;
         fin_in  = head_job.fin && last;
         bad_in  = head_job.bad;
         idx_in  = last ? 2'd0 : idx_ff + 2'd1;
      end else if (rsp.ready) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
         vld_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         vld_ff <= vld_in;
      end
      byte_ff <= byte_in;
      bv_ff   <= bv_in;
      fin_ff  <= fin_in;
      bad_ff  <= bad_in;
   end

   assign rsp.valid        = vld_ff;
   assign rsp.out_byte     = byte_ff;
   assign rsp.byte_valid   = bv_ff;
   assign rsp.final_result = fin_ff;
   assign rsp.bad_length   = bad_ff;

endmodule

### bench/base64_stream_decoder_tb.sv
// Testbench for base64_stream_decoder: known base64 vectors, then random encoded streams
// under several sender and receiver gap patterns, checked against an in-bench predictor.
// Depends on b64d_pkg, the b64d_req_if / b64d_rsp_if interfaces and the decoder RTL.
module base64_stream_decoder_tb
   import b64d_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam string Alphabet =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
   localparam int ItemsPerPhase = 96;
   localparam int MaxReported = 10;

   // One decoded result as it should leave the response channel
   typedef struct packed {
      logic [7:0] data;
      logic       valid;
      logic       last;
      logic       bad;
   } decoded_byte_type;

   logic clock;
   logic reset;

   b64d_req_if req_chan();
   b64d_rsp_if rsp_chan();

   base64_stream_decoder dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // Predictor state, cleared at the end of every source
   logic [23:0] shift_acc;
   logic [1:0]  held_symbols;
   logic        pad_latched;

   decoded_byte_type pending_bytes[$];

   int send_idle_pct;
   int rsp_stall_pct;
   int errors;
   int items_used;
   int items_sent;
   int streams_sent;
   int bytes_checked;
   int short_tails;

   always #5 clock = ~clock;

   // Run limit, far above the slowest legal run
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // 6-bit value of an alphabet character, -1 for anything else
   function automatic int alpha_index(input logic [7:0] c);
      for (int i = 0; i < 64; i++) begin
         if (Alphabet[i] == c) begin
            return i;
         end
      end
      return -1;
   endfunction

   function automatic void expect_byte(input logic [7:0] data, input logic valid,
                                       input logic last, input logic bad);
      pending_bytes.push_back('{data: data, valid: valid, last: last, bad: bad});
      if (bad) begin
         short_tails++;
      end
   endfunction

   // Update the decoder state for one accepted request and queue what it produces.
   // Returns 1 when the request had any effect on the decoder.
   function automatic bit predict_decoded_bytes(input logic [7:0] c, input logic eos);
      int  v;
      int  produced;
      bit  used;
      produced = 0;
      used = eos;
      if (!pad_latched) begin
         if (c == PadChar) begin
            pad_latched = 1'b1;
            used = 1'b1;
         end else begin
            v = alpha_index(c);
            if (v >= 0) begin
               used = 1'b1;
               shift_acc = {shift_acc[17:0], 6'(v)};
               if (held_symbols == 2'd3) begin
                  expect_byte(shift_acc[23:16], 1'b1, 1'b0, 1'b0);
                  expect_byte(shift_acc[15:8], 1'b1, 1'b0, 1'b0);
                  expect_byte(shift_acc[7:0], 1'b1, eos, 1'b0);
                  produced = 3;
                  shift_acc = '0;
                  held_symbols = '0;
               end else begin
                  held_symbols = held_symbols + 2'd1;
               end
            end
         end
      end
      // End of source: flush leftover symbols, then clear everything
      if (eos) begin
         if (produced == 0) begin
            case (held_symbols)
               2'd1: expect_byte(8'h00, 1'b0, 1'b1, 1'b1);
               2'd2: expect_byte(shift_acc[11:4], 1'b1, 1'b1, 1'b0);
               2'd3: begin
                  expect_byte(shift_acc[17:10], 1'b1, 1'b0, 1'b0);
                  expect_byte(shift_acc[9:2], 1'b1, 1'b1, 1'b0);
               end
               default: expect_byte(8'h00, 1'b0, 1'b1, 1'b0);
            endcase
         end
         shift_acc = '0;
         held_symbols = '0;
         pad_latched = 1'b0;
      end
      return used;
   endfunction

   // Response checker and sink-side stalls
   always @(posedge clock) begin
      decoded_byte_type want;
      decoded_byte_type got;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         got = '{data: rsp_chan.out_byte, valid: rsp_chan.byte_valid,
                 last: rsp_chan.final_result, bad: rsp_chan.bad_length};
         if (pending_bytes.size() == 0) begin
            errors++;
            if (errors <= MaxReported) begin
               $display("unexpected response: byte %h valid %b last %b bad %b",
                        got.data, got.valid, got.last, got.bad);
            end
         end else begin
            want = pending_bytes.pop_front();
            bytes_checked++;
            if (got.data !== want.data || got.valid !== want.valid ||
                got.last !== want.last || got.bad !== want.bad) begin
               errors++;
               if (errors <= MaxReported) begin
                  $display("mismatch on response %0d: expected byte %h valid %b last %b bad %b,",
                           bytes_checked, want.data, want.valid, want.last, want.bad);
                  $display("   got byte %h valid %b last %b bad %b",
                           got.data, got.valid, got.last, got.bad);
               end
            end
         end
      end
      rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Send one character request; valid stays high after acceptance
   task automatic send_char(input logic [7:0] c, input logic eos);
      if ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         req_chan.in_char <= 8'($urandom_range(255));
         req_chan.end_of_source <= 1'($urandom_range(1));
         do @(posedge clock); while ($urandom_range(99) < send_idle_pct);
      end
      req_chan.valid <= 1'b1;
      req_chan.in_char <= c;
      req_chan.end_of_source <= eos;
      do @(posedge clock); while (!req_chan.ready);
      items_sent++;
      if (predict_decoded_bytes(c, eos)) begin
         items_used++;
      end
      if (eos) begin
         streams_sent++;
      end
   endtask

   task automatic send_text(input string s, input bit close);
      foreach (s[i]) begin
         send_char(s[i], close && (i == s.len() - 1));
      end
   endtask

   // Hold the sender off until every queued result has been seen
   task automatic drain_responses();
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (pending_bytes.size() != 0);
   endtask

   function automatic logic [7:0] random_symbol();
      return Alphabet[$urandom_range(63)];
   endfunction

   function automatic logic [7:0] random_junk();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (alpha_index(c) >= 0 || c == PadChar);
      return c;
   endfunction

   // One random source: mostly well-formed groups with a random tail, some noise
   task automatic send_random_stream();
      logic [7:0] src[$];
      int groups;
      int tail;
      int kind;
      int pos;
      groups = $urandom_range(0, 3);
      tail = $urandom_range(0, 3);
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
         repeat ($urandom_range(1, 10)) src.push_back(8'($urandom_range(255)));
      end else begin
         repeat (groups * 4 + tail) src.push_back(random_symbol());
         if (tail >= 2 && $urandom_range(1) == 1) begin
            repeat (4 - tail) src.push_back(PadChar);
         end
         // characters after a pad must be ignored
         if (kind == 1) begin
            src.push_back(PadChar);
            repeat ($urandom_range(1, 4)) src.push_back(8'($urandom_range(255)));
         end
         // stray characters inside the stream
         if (kind == 2) begin
            repeat ($urandom_range(1, 3)) begin
               pos = $urandom_range(0, src.size());
               src.insert(pos, random_junk());
            end
         end
      end
      if (src.size() == 0) begin
         src.push_back(random_junk());
      end
      foreach (src[i]) begin
         send_char(src[i], i == src.size() - 1);
      end
   endtask

   task automatic run_random_streams(input int target);
      int start;
      start = items_sent;
      while (items_sent - start < target) begin
         send_random_stream();
      end
      drain_responses();
   endtask

   // Known vectors: full group on the end character, pad tails, short tail, empty end
   task automatic test_known_vectors();
      send_text("TWFu", 1'b1);
      send_text("TQ==", 1'b1);
      send_text("TWE", 1'b0);
      send_char(PadChar, 1'b1);
      send_text("/+9z", 1'b0);
      send_char("A", 1'b0);
      send_char(8'hFF, 1'b1);
      send_char(8'h00, 1'b1);
      send_char(PadChar, 1'b0);
      send_text("Zm9", 1'b1);
      drain_responses();
   endtask

   task automatic test_back_to_back();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      run_random_streams(ItemsPerPhase);
   endtask

   task automatic test_sparse_source();
      send_idle_pct = 84;
      rsp_stall_pct = 0;
      run_random_streams(ItemsPerPhase);
   endtask

   task automatic test_slow_sink();
      send_idle_pct = 0;
      rsp_stall_pct = 84;
      run_random_streams(ItemsPerPhase);
   endtask

   task automatic test_mixed_gaps();
      send_idle_pct = 30;
      rsp_stall_pct = 30;
      run_random_streams(ItemsPerPhase);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.in_char = 8'h00;
      req_chan.end_of_source = 1'b0;
      rsp_chan.ready = 1'b0;
      shift_acc = '0;
      held_symbols = '0;
      pad_latched = 1'b0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      errors = 0;
      items_used = 0;
      items_sent = 0;
      streams_sent = 0;
      bytes_checked = 0;
      short_tails = 0;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_known_vectors();
      test_back_to_back();
      test_sparse_source();
      test_slow_sink();
      test_mixed_gaps();

      // settle, so late extra responses are caught
      repeat (20) @(posedge clock);
      errors += pending_bytes.size();

      $display("Decoded %0d sources from %0d characters (%0d effective); %0d responses checked,",
               streams_sent, items_sent, items_used, bytes_checked);
      $display("%0d of them single-symbol tails, across four gap patterns.", short_tails);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
